@@ src/kcm_pkg.sv @@
// shared types and constants for the key chord matcher
package kcm_pkg;

    localparam int MAX_MEMBERS = 8;
    localparam int KEY_ID_BITS = 8;
    localparam int KEY_W       = 8;
    localparam int SLOT_W      = 8;
    localparam int CNT_W       = 4;
    localparam int STATE_W     = 3;
    localparam int CFG_W       = 64;
    localparam int CFG_IDX_W   = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MEMBER_IDS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MEMBER_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FORBID_EARLY  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PEDANTIC_MODE = 2'd3;

    // chord state codes
    localparam logic [STATE_W-1:0] ST_PROGRESS  = 3'd0;
    localparam logic [STATE_W-1:0] ST_MATCHES   = 3'd1;
    localparam logic [STATE_W-1:0] ST_FINALIZED = 3'd2;
    localparam logic [STATE_W-1:0] ST_INVALID   = 3'd3;
    localparam logic [STATE_W-1:0] ST_RELEASING = 3'd4;

    // op codes
    localparam logic OP_EVENT   = 1'b0;
    localparam logic OP_RESTART = 1'b1;

    typedef struct packed {
        logic             op;
        logic [KEY_W-1:0] key_id;
        logic             key_pressed;
        logic             probe_only;
    } t_in_item;

    typedef struct packed {
        logic               consumed;
        logic [STATE_W-1:0] chord_state;
        logic [CNT_W-1:0]   active_count;
    } t_out_item;

    // handed from cell to cell: has a lower slot matched, and its held bit
    typedef struct packed {
        logic found;
        logic held;
    } t_chain;

    // update strobes broadcast to all cells
    typedef struct packed {
        logic restart;
        logic press;
        logic release_key;
    } t_cell_cmd;

endpackage

@@ src/kcm_cell.sv @@
// one member slot: id compare, priority chain link and held bit
module kcm_cell import kcm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [SLOT_W-1:0] i_member_id,
    input  logic              i_in_use,
    input  logic [KEY_W-1:0]  i_key_id,
    input  t_chain            i_chain,
    input  t_cell_cmd         i_cmd,
    output t_chain            o_chain
);

    logic r_held;
    logic w_match;
    logic w_hit;

    assign w_match = i_in_use &&
        (i_member_id[KEY_ID_BITS-1:0] == i_key_id[KEY_ID_BITS-1:0]);
    // lowest matching slot takes the event
    assign w_hit = w_match && !i_chain.found;

    always_comb begin
        o_chain = i_chain;
        if (w_hit) begin
            o_chain.found = 1'b1;
            o_chain.held  = r_held;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held <= 1'b0;
        end else if (i_cmd.restart) begin
            r_held <= 1'b0;
        end else if (i_cmd.press && w_hit) begin
            r_held <= 1'b1;
        end else if (i_cmd.release_key && w_hit) begin
            r_held <= 1'b0;
        end
    end

endmodule

@@ src/kcm_ctrl.sv @@
// chord count, completion and state tracking plus the result register
module kcm_ctrl import kcm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  t_in_item         i_item,
    input  t_chain           i_chain,
    input  logic [CNT_W-1:0] i_members,
    input  logic             i_forbid_early,
    input  logic             i_pedantic,
    input  logic             i_out_take,
    output t_cell_cmd        o_cmd,
    output logic             o_out_valid,
    output t_out_item        o_out_data
);

    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_completed, n_completed;
    logic [STATE_W-1:0] r_status, n_status;
    logic               n_taken;
    logic               r_out_valid;
    t_out_item          r_out_data;
    logic               w_release_ok;

    assign w_release_ok = r_completed || !i_forbid_early;

    always_comb begin
        n_count     = r_count;
        n_completed = r_completed;
        n_status    = r_status;
        n_taken     = 1'b0;
        o_cmd       = '0;
        if (i_item.op == OP_RESTART) begin
            o_cmd.restart = 1'b1;
            n_count       = '0;
            n_completed   = 1'b0;
            n_status      = ST_PROGRESS;
        end else if (!i_chain.found) begin
            if (i_item.key_pressed && !i_item.probe_only) begin
                n_status = ST_INVALID;
            end
        end else if (!i_item.key_pressed && !w_release_ok) begin
            if (!i_item.probe_only) begin
                n_status = ST_INVALID;
            end
        end else if (!i_item.key_pressed && !i_chain.held) begin
            n_taken = 1'b0;
        end else begin
            n_taken = 1'b1;
            if (i_item.key_pressed) begin
                o_cmd.press = 1'b1;
                if (!i_chain.held) begin
                    n_count = r_count + 1'b1;
                end
            end else begin
                o_cmd.release_key = 1'b1;
                n_count = r_count - 1'b1;
            end
            n_status = ST_PROGRESS;
            if (n_count == i_members) begin
                n_completed = 1'b1;
                n_status    = ST_MATCHES;
            end else if (n_count == '0) begin
                if (r_completed) begin
                    n_status = i_pedantic ? ST_MATCHES : ST_FINALIZED;
                end
            end else if (r_completed) begin
                n_status = ST_RELEASING;
            end
        end
        if (!i_accept) begin
            o_cmd = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_completed <= 1'b0;
            r_status    <= ST_PROGRESS;
            r_out_valid <= 1'b0;
        end else begin
            if (i_accept) begin
                r_count     <= n_count;
                r_completed <= n_completed;
                r_status    <= n_status;
                r_out_valid <= 1'b1;
            end else if (i_out_take) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_out_data.consumed     <= n_taken;
            r_out_data.chord_state  <= n_status;
            r_out_data.active_count <= n_count;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

@@ src/key_chord_matcher.sv @@
// top level of the key chord matcher: configuration, cell row and control
//
// Tracks one chord of up to eight member keys. Each key event or restart
// transaction yields exactly one result transaction (consumed flag, chord
// state, held member count). An event is taken every clock cycle: the id
// compare runs as a priority chain through a row of eight slot cells, each
// holding its member's held bit, and the count and state update in the same
// cycle, so an event's result appears in the cycle after acceptance. The
// result register frees as it is taken, so input is stalled only while a
// result waits and the output is stalled. Configuration writes take effect
// on the next cycle and are to be made while no transaction is in flight.
module key_chord_matcher import kcm_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    logic [CFG_W-1:0] r_member_ids;
    logic [CNT_W-1:0] r_member_count;
    logic             r_forbid_early;
    logic             r_pedantic;
    logic [CNT_W-1:0] w_members;
    logic             w_accept;
    logic             w_out_take;
    t_chain           w_chain [MAX_MEMBERS+1];
    t_cell_cmd        w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_member_ids   <= '0;
            r_member_count <= CNT_W'(1);
            r_forbid_early <= 1'b0;
            r_pedantic     <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_MEMBER_IDS:    r_member_ids   <= i_cfg_data;
                REG_MEMBER_COUNT:  r_member_count <= i_cfg_data[CNT_W-1:0];
                REG_FORBID_EARLY:  r_forbid_early <= i_cfg_data[0];
                REG_PEDANTIC_MODE: r_pedantic     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // zero counts as one member, larger counts saturate
    always_comb begin
        if (r_member_count == '0) begin
            w_members = CNT_W'(1);
        end else if (r_member_count > CNT_W'(MAX_MEMBERS)) begin
            w_members = CNT_W'(MAX_MEMBERS);
        end else begin
            w_members = r_member_count;
        end
    end

    assign w_out_take = o_out_valid && !i_out_stall;
    assign o_in_stall = o_out_valid && i_out_stall;
    assign w_accept   = i_in_valid && !o_in_stall;

    assign w_chain[0] = '0;

    for (genvar k = 0; k < MAX_MEMBERS; k++) begin : g_cell
        kcm_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_member_id (r_member_ids[k*SLOT_W +: SLOT_W]),
            .i_in_use    (CNT_W'(k) < w_members),
            .i_key_id    (i_in_data.key_id),
            .i_chain     (w_chain[k]),
            .i_cmd       (w_cmd),
            .o_chain     (w_chain[k+1])
        );
    end

    kcm_ctrl u_ctrl (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (w_accept),
        .i_item         (i_in_data),
        .i_chain        (w_chain[MAX_MEMBERS]),
        .i_members      (w_members),
        .i_forbid_early (r_forbid_early),
        .i_pedantic     (r_pedantic),
        .i_out_take     (w_out_take),
        .o_cmd          (w_cmd),
        .o_out_valid    (o_out_valid),
        .o_out_data     (o_out_data)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps
// self-checking testbench for the key chord matcher: queued stimulus, in-bench predictor
module tb_top;
    import kcm_pkg::*;

    localparam int HALF_PERIOD   = 4;
    localparam int CYCLE_LIMIT   = 600000;
    localparam int RANDOM_PHASES = 9;
    localparam int PHASE_ITEMS   = 130;
    localparam int LONG_HOLD     = 150;
    localparam int IN_W          = $bits(t_in_item);

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_item             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_item            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [CFG_W-1:0]     i_cfg_data  = '0;

    // shadow copy of the configuration registers
    bit [CFG_W-1:0] cfg_ids      = '0;
    bit [CNT_W-1:0] cfg_count    = 4'd1;
    bit             cfg_forbid   = 1'b0;
    bit             cfg_pedantic = 1'b0;

    // predicted chord state
    bit [MAX_MEMBERS-1:0] held_mask    = '0;
    bit [CNT_W-1:0]       held_cnt     = '0;
    bit                   chord_done   = 1'b0;
    logic [STATE_W-1:0]   chord_status = ST_PROGRESS;

    t_in_item    key_event_q[$];
    t_out_item   chord_result_q[$];
    t_out_item   want;
    int unsigned slot_order[MAX_MEMBERS];
    int unsigned n_queued    = 0;
    int unsigned n_results   = 0;
    int unsigned n_errors    = 0;
    int unsigned cycle_count = 0;
    int unsigned send_gap    = 0;
    int unsigned stall_left  = 0;
    bit          quiet_phase = 1'b0;

    key_chord_matcher i_dut (.*);

    always #HALF_PERIOD i_clk = ~i_clk;

    function automatic int unsigned chord_size();
        if (cfg_count == 0) return 1;
        if (cfg_count > MAX_MEMBERS) return MAX_MEMBERS;
        return cfg_count;
    endfunction

    function automatic logic [KEY_W-1:0] member_key(int unsigned slot);
        return cfg_ids[KEY_W*slot +: KEY_W];
    endfunction

    function automatic int unsigned pick_idle();
        int unsigned r;
        if (quiet_phase) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic t_out_item predict_chord(t_in_item item);
        t_out_item   res;
        int unsigned n;
        int          slot;
        bit          taken;
        n = chord_size();
        slot = -1;
        taken = 1'b0;
        if (item.op == OP_RESTART) begin
            held_mask = '0;
            held_cnt = '0;
            chord_done = 1'b0;
            chord_status = ST_PROGRESS;
        end else begin
            // scan downward so the lowest matching slot wins
            for (int i = MAX_MEMBERS - 1; i >= 0; i--) begin
                if (i < n && member_key(i) == item.key_id) slot = i;
            end
            if (slot < 0) begin
                if (item.key_pressed && !item.probe_only) chord_status = ST_INVALID;
            end else if (item.key_pressed) begin
                if (!held_mask[slot]) begin
                    held_mask[slot] = 1'b1;
                    held_cnt = held_cnt + 1'b1;
                end
                taken = 1'b1;
            end else if (!chord_done && cfg_forbid) begin
                if (!item.probe_only) chord_status = ST_INVALID;
            end else if (held_mask[slot]) begin
                held_mask[slot] = 1'b0;
                held_cnt = held_cnt - 1'b1;
                taken = 1'b1;
            end
            if (taken) begin
                if (held_cnt == n) begin
                    chord_done = 1'b1;
                    chord_status = ST_MATCHES;
                end else if (held_cnt == 0) begin
                    chord_status = !chord_done ? ST_PROGRESS :
                                   cfg_pedantic ? ST_MATCHES : ST_FINALIZED;
                end else begin
                    chord_status = chord_done ? ST_RELEASING : ST_PROGRESS;
                end
            end
        end
        res.consumed = taken;
        res.chord_state = chord_status;
        res.active_count = held_cnt;
        return res;
    endfunction

    task automatic queue_key(logic [KEY_W-1:0] key, bit pressed, bit probe);
        t_in_item item;
        item.op = OP_EVENT;
        item.key_id = key;
        item.key_pressed = pressed;
        item.probe_only = probe;
        key_event_q.push_back(item);
        n_queued++;
    endtask

    task automatic queue_restart();
        t_in_item item;
        // the other fields are don't-care on a restart, so randomize them
        item = IN_W'($urandom_range(0, (1 << IN_W) - 1));
        item.op = OP_RESTART;
        key_event_q.push_back(item);
        n_queued++;
    endtask

    task automatic queue_noise();
        queue_key(KEY_W'($urandom_range(0, 255)), 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)));
    endtask

    task automatic shuffle_slots(int unsigned len);
        int unsigned j;
        int unsigned tmp;
        for (int i = int'(len) - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            tmp = slot_order[i];
            slot_order[i] = slot_order[j];
            slot_order[j] = tmp;
        end
    endtask

    // press the members in random order, then release them; some rounds break off early
    task automatic queue_chord_round();
        int unsigned n;
        int unsigned reach;
        bit          broken;
        n = chord_size();
        broken = ($urandom_range(0, 3) == 0);
        reach = broken ? $urandom_range(0, n - 1) : n;
        for (int i = 0; i < MAX_MEMBERS; i++) slot_order[i] = i;
        shuffle_slots(n);
        for (int i = 0; i < reach; i++) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            queue_key(member_key(slot_order[i]), 1'b1, $urandom_range(0, 3) == 0);
            if ($urandom_range(0, 7) == 0) queue_key(member_key(slot_order[i]), 1'b1, 1'b0);
        end
        shuffle_slots(reach);
        for (int i = 0; i < reach; i++) begin
            if ($urandom_range(0, 9) == 0) queue_noise();
            queue_key(member_key(slot_order[i]), 1'b0, $urandom_range(0, 3) == 0);
        end
        if (broken || $urandom_range(0, 5) == 0) queue_restart();
    endtask

    // call right after a rising edge; writes every register once
    task automatic apply_settings(bit [CFG_W-1:0] ids, bit [CNT_W-1:0] count,
                                  bit forbid, bit pedantic);
        cfg_ids = ids;
        cfg_count = count;
        cfg_forbid = forbid;
        cfg_pedantic = pedantic;
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_MEMBER_IDS;
        i_cfg_data <= ids;
        @(posedge i_clk);
        i_cfg_idx  <= REG_MEMBER_COUNT;
        i_cfg_data <= CFG_W'(count);
        @(posedge i_clk);
        i_cfg_idx  <= REG_FORBID_EARLY;
        i_cfg_data <= CFG_W'(forbid);
        @(posedge i_clk);
        i_cfg_idx  <= REG_PEDANTIC_MODE;
        i_cfg_data <= CFG_W'(pedantic);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        while (n_results < n_queued) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                chord_result_q.push_back(predict_chord(i_in_data));
            end
            if (!(i_in_valid && o_in_stall)) begin
                if (send_gap > 0) begin
                    i_in_valid <= 1'b0;
                    send_gap--;
                end else if (key_event_q.size() != 0) begin
                    i_in_data  <= key_event_q.pop_front();
                    i_in_valid <= 1'b1;
                    send_gap = pick_idle();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (chord_result_q.size() == 0) begin
                    $error("result transaction with no expectation pending");
                    n_errors++;
                end else begin
                    want = chord_result_q.pop_front();
                    if (o_out_data.consumed !== want.consumed) begin
                        $error("consumed: expected %0d, actual %0d",
                               want.consumed, o_out_data.consumed);
                        n_errors++;
                    end
                    if (o_out_data.chord_state !== want.chord_state) begin
                        $error("chord_state: expected %0d, actual %0d",
                               want.chord_state, o_out_data.chord_state);
                        n_errors++;
                    end
                    if (o_out_data.active_count !== want.active_count) begin
                        $error("active_count: expected %0d, actual %0d",
                               want.active_count, o_out_data.active_count);
                        n_errors++;
                    end
                end
                n_results++;
                // long back-pressure so the result register fills and input stalls
                if (n_results == 400 || n_results == 900) stall_left = LONG_HOLD;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                stall_left = pick_idle();
                i_out_stall <= (stall_left != 0);
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL key_chord_matcher");
            $finish;
        end
    end

    initial begin : stimulus
        bit [CFG_W-1:0] ids;
        bit [CNT_W-1:0] count;
        int unsigned    phase_start;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // registers at reset: one member with id zero
        queue_key(8'h00, 1'b1, 1'b0);   // completes at once
        queue_key(8'h00, 1'b1, 1'b0);   // repeated press of a held member
        queue_key(8'hFF, 1'b1, 1'b1);   // foreign press under probe, state kept
        queue_key(8'hFF, 1'b0, 1'b0);   // foreign release ignored
        queue_key(8'h00, 1'b0, 1'b0);   // full release gives finalized
        queue_key(8'h00, 1'b0, 1'b0);   // release of a key not held
        queue_key(8'h80, 1'b1, 1'b0);   // foreign press marks invalid
        queue_restart();
        wait_idle();

        // three members, duplicate id in slot 3, early release forbidden, pedantic
        apply_settings(64'h7E80_015A_FFA5_FF00, 4'd3, 1'b1, 1'b1);
        queue_key(8'h00, 1'b1, 1'b0);
        queue_key(8'h00, 1'b0, 1'b0);   // early release refused, invalid
        queue_key(8'h00, 1'b0, 1'b1);   // early release refused under probe
        queue_key(8'hFF, 1'b1, 1'b0);
        queue_key(8'hA5, 1'b1, 1'b0);   // chord matches
        queue_key(8'hFF, 1'b0, 1'b0);   // releasing
        queue_key(8'h5A, 1'b1, 1'b0);   // slot beyond member count is foreign
        queue_key(8'h00, 1'b0, 1'b0);
        queue_key(8'hA5, 1'b0, 1'b0);   // pedantic full release reports matches
        queue_key(8'hFF, 1'b1, 1'b0);
        queue_key(8'hA5, 1'b1, 1'b0);
        queue_key(8'h00, 1'b1, 1'b0);
        wait_idle();

        // member count lowered while three keys are held
        apply_settings(64'h7E80_015A_FFA5_FF00, 4'd1, 1'b0, 1'b0);
        queue_key(8'h00, 1'b1, 1'b0);
        queue_key(8'hFF, 1'b0, 1'b0);
        queue_key(8'h00, 1'b0, 1'b0);
        queue_restart();
        wait_idle();

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case ($urandom_range(0, 7))
                0: ids = '1;
                1: ids = '0;
                2: begin
                    ids = {$urandom, $urandom};
                    ids[15:8] = ids[7:0];
                    ids[47:40] = ids[7:0];
                end
                default: ids = {$urandom, $urandom};
            endcase
            if (phase == 0) count = 4'd8;
            else if (phase == 1) count = 4'd0;
            else if (phase == 2) count = 4'd15;
            else count = CNT_W'($urandom_range(1, 8));
            quiet_phase = (phase == 4);
            apply_settings(ids, count, 1'(phase % 2), 1'((phase / 2) % 2));
            phase_start = n_queued;
            while (n_queued - phase_start < PHASE_ITEMS) queue_chord_round();
            wait_idle();
        end

        if (chord_result_q.size() != 0) begin
            $error("%0d expected results never arrived", chord_result_q.size());
            n_errors++;
        end
        if (n_errors == 0) begin
            $display("PASS key_chord_matcher");
        end else begin
            $display("FAIL key_chord_matcher");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/kcm_pkg.sv
src/kcm_cell.sv
src/kcm_ctrl.sv
src/key_chord_matcher.sv
bench/tb_top.sv
